FILE: hw/rtl/rlbe_pkg.sv
// ----------------------------------------------------------------------------
// rlbe_pkg
// Types and constants shared by the run-length byte encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlbe_pkg;

    localparam int ByteWidth      = 8;
    localparam int RunWidth       = 4;
    localparam int BurstDepth     = 4;
    localparam int CountWidth     = $clog2(BurstDepth + 1);
    localparam int CfgAddrWidth   = 3;
    localparam int CfgDataWidth   = 32;

    localparam logic [ByteWidth-1:0] DIGIT_ZERO    = 8'h30;
    localparam logic [RunWidth-1:0]  LIMIT_LOW     = 4'd2;
    localparam logic [RunWidth-1:0]  LIMIT_HIGH    = 4'd10;
    localparam logic [RunWidth-1:0]  MAX_RUN_RESET = 4'd10;

    localparam logic REG_MAX_RUN_LENGTH = 1'b0;

    typedef struct packed {
        logic [ByteWidth-1:0] data_byte;
        logic                 end_of_message;
    } item_t;

    typedef struct packed {
        logic [ByteWidth-1:0] coded_byte;
        logic                 final_byte;
    } code_t;

endpackage

FILE: hw/rtl/run_length_byte_encoder.sv
// ----------------------------------------------------------------------------
// run_length_byte_encoder
// Output: an item's first coded byte is presented in the cycle after its transfer.
// Throughput: one item per cycle while code_ready is high and each item codes 0 or 1
// bytes; an item of k bytes (0 to 4) holds the input until the four-entry burst drains.
// Reset: rst_n clears the held run and empties the burst; max_run_length returns to 10.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module run_length_byte_encoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  rlbe_pkg::item_t                   item,
    output logic                              code_valid,
    input  logic                              code_ready,
    output rlbe_pkg::code_t                   code,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rlbe_pkg::CfgAddrWidth-1:0] paddr,
    input  logic [rlbe_pkg::CfgDataWidth-1:0] pwdata,
    output logic [rlbe_pkg::CfgDataWidth-1:0] prdata,
    output logic                              pready
);
    import rlbe_pkg::*;

    logic [RunWidth-1:0]   max_run_reg;
    logic [ByteWidth-1:0]  held_byte_reg;
    logic [ByteWidth-1:0]  held_byte_next;
    logic                  held_valid_reg;
    logic                  held_valid_next;
    logic [RunWidth-1:0]   run_length_reg;
    logic [RunWidth-1:0]   run_length_next;
    code_t                 burst_reg [BurstDepth];
    code_t                 burst_next [BurstDepth];
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic [CountWidth-1:0] first_count;
    logic [RunWidth-1:0]   limit;
    logic                  same_run;
    logic                  accept;
    logic                  pop;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[CfgAddrWidth-1] == REG_MAX_RUN_LENGTH);
    assign prdata    = (paddr[CfgAddrWidth-1] == REG_MAX_RUN_LENGTH)
                       ? {{(CfgDataWidth-RunWidth){1'b0}}, max_run_reg}
                       : '0;

    assign code_valid = (count_reg != '0);
    assign code       = burst_reg[0];
    assign pop        = code_valid && code_ready;
    assign item_ready = (count_reg == '0)
                        || ((count_reg == CountWidth'(1)) && code_ready);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        limit = max_run_reg;
        if (limit < LIMIT_LOW)
        begin
            limit = LIMIT_LOW;
        end
        if (limit > LIMIT_HIGH)
        begin
            limit = LIMIT_HIGH;
        end
    end

    assign same_run = held_valid_reg && (held_byte_reg == item.data_byte)
                      && (run_length_reg < limit);

    always_comb
    begin
        for (int i = 0; i < BurstDepth; i++)
        begin
            burst_next[i] = '{coded_byte: held_byte_reg, final_byte: 1'b0};
        end
        first_count     = '0;
        count_next      = '0;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        run_length_next = run_length_reg;

        if (same_run)
        begin
            run_length_next = run_length_reg + RunWidth'(1);
            if (item.end_of_message)
            begin
                burst_next[2] = '{coded_byte: DIGIT_ZERO
                                      + {{(ByteWidth-RunWidth){1'b0}}, run_length_reg}
                                      - ByteWidth'(1),
                                  final_byte: 1'b1};
                count_next    = CountWidth'(3);
            end
        end
        else
        begin
            held_byte_next  = item.data_byte;
            held_valid_next = 1'b1;
            run_length_next = RunWidth'(1);
            if (held_valid_reg)
            begin
                if (run_length_reg <= RunWidth'(1))
                begin
                    first_count = CountWidth'(1);
                end
                else
                begin
                    burst_next[2].coded_byte = DIGIT_ZERO
                                               + {{(ByteWidth-RunWidth){1'b0}}, run_length_reg}
                                               - ByteWidth'(2);
                    first_count = CountWidth'(3);
                end
            end
            count_next = first_count;
            if (item.end_of_message)
            begin
                burst_next[first_count[1:0]] = '{coded_byte: item.data_byte,
                                                 final_byte: 1'b1};
                count_next = first_count + CountWidth'(1);
            end
        end

        if (item.end_of_message)
        begin
            held_valid_next = 1'b0;
            run_length_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_run_reg    <= MAX_RUN_RESET;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            run_length_reg <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                max_run_reg <= pwdata[RunWidth-1:0];
            end
            if (accept)
            begin
                held_byte_reg  <= held_byte_next;
                held_valid_reg <= held_valid_next;
                run_length_reg <= run_length_next;
                count_reg      <= count_next;
            end
            else if (pop)
            begin
                count_reg <= count_reg - CountWidth'(1);
            end
        end
    end

    // load a fresh burst on transfer, else advance on each output transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < BurstDepth; i++)
            begin
                burst_reg[i] <= burst_next[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < BurstDepth - 1; i++)
            begin
                burst_reg[i] <= burst_reg[i+1];
            end
        end
    end

endmodule
